// File: hw/rtl/json_string_unescape_utf8_top_macros.svh
// ----------------------------------------------------------------------------
// json_string_unescape_utf8_top_macros.svh
// Assertion macros used by the string unescape checker.
// ----------------------------------------------------------------------------
`ifndef JSON_STRING_UNESCAPE_UTF8_TOP_MACROS_SVH
`define JSON_STRING_UNESCAPE_UTF8_TOP_MACROS_SVH

// Check a condition in the same cycle as its trigger.
`define JSU_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Check a condition in the cycle after its trigger.
`define JSU_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hw/rtl/jsu_pkg.sv
// ----------------------------------------------------------------------------
// jsu_pkg
// Types and codes for the JSON string unescape to UTF-8 block.
// ----------------------------------------------------------------------------
package jsu_pkg;

  // Decoder phase within a string body
  typedef enum logic [3:0] {
    PH_TEXT,
    PH_ESC,
    PH_HEX_A,
    PH_WANT_BS,
    PH_WANT_U,
    PH_HEX_B,
    PH_ENDED,
    PH_FAILED
  } phase_t;

  // Result kinds
  typedef enum logic [1:0] {
    KIND_BYTE  = 2'd0,
    KIND_END   = 2'd1,
    KIND_ERROR = 2'd2
  } kind_t;

  // Error codes
  localparam logic [2:0] ERR_QUOTE     = 3'd0;
  localparam logic [2:0] ERR_ESCAPE    = 3'd1;
  localparam logic [2:0] ERR_HEX       = 3'd2;
  localparam logic [2:0] ERR_SURROGATE = 3'd3;
  localparam logic [2:0] ERR_CONTROL   = 3'd4;

  // One raw input byte request
  typedef struct packed {
    logic [7:0] in_byte;
    logic       restart;
  } byte_req_t;

  // One decoded result
  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] out_byte;
    logic [2:0] error_code;
    logic       last;
  } result_t;

endpackage

// File: hw/rtl/json_string_unescape_utf8_top.sv
// ----------------------------------------------------------------------------
// json_string_unescape_utf8_top
// Decodes JSON string body bytes (escapes, \uXXXX, surrogate pairs) to UTF-8.
// ----------------------------------------------------------------------------
// Usage:
//   The byte channel (byte_valid / byte_stall / byte_data) takes one raw byte
//   of a string body per request; restart marks the first byte of a string.
//   The result channel (res_valid / res_stall / res_data) returns decoded
//   UTF-8 bytes, an end marker on the closing quote, or one error; last flags
//   the final result caused by an input byte.
//   The first result of a byte is offered once the byte has passed the input
//   register and been decoded into the result group register; a busy group
//   register can hold the byte in the input register. Throughput: one byte per
//   cycle while each byte makes at most one result and the receiver does not
//   stall. A code point of n UTF-8 bytes holds the result group register
//   until its n bytes are taken, which sets the rate during multi-byte output;
//   bytes that make no result pass even while the group register is busy.
//   Reset clears the decoder to plain text and empties both registers.
//   A stalled receiver holds the current result; the input register then
//   fills and byte_stall rises until the group register drains.
// ----------------------------------------------------------------------------
module json_string_unescape_utf8_top (
  input  logic               clk,
  input  logic               rst,
  input  logic               byte_valid,
  output logic               byte_stall,
  input  jsu_pkg::byte_req_t byte_data,
  output logic               res_valid,
  input  logic               res_stall,
  output jsu_pkg::result_t   res_data
);
  import jsu_pkg::*;

  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_B      = 8'h62;
  localparam logic [7:0] CH_F      = 8'h66;
  localparam logic [7:0] CH_N      = 8'h6E;
  localparam logic [7:0] CH_R      = 8'h72;
  localparam logic [7:0] CH_T      = 8'h74;
  localparam logic [7:0] CH_U      = 8'h75;

  // Hex digit value with a valid flag in the top bit
  function automatic logic [4:0] hex_value(input logic [7:0] b);
    if (b >= 8'h30 && b <= 8'h39) begin
      return {1'b1, b[3:0]};
    end else if ((b >= 8'h41 && b <= 8'h46) || (b >= 8'h61 && b <= 8'h66)) begin
      return {1'b1, 4'(b[3:0] + 4'd9)};
    end
    return 5'd0;
  endfunction

  // Input register
  logic      inq_valid;
  byte_req_t inq;

  // Decoder state
  phase_t      phase, phase_next;
  logic [15:0] hex_accum, hex_accum_next;
  logic [15:0] high_surrogate, high_surrogate_next;
  logic [1:0]  digit_count, digit_count_next;

  // Result group register
  logic       grp_valid;
  kind_t      grp_kind;
  logic [2:0] grp_code;
  logic [7:0] grp_bytes [4];
  logic [1:0] grp_cnt;
  logic [1:0] grp_idx;

  // Decode outputs
  phase_t      ph;
  logic [15:0] acc, hs, acc_shift;
  logic [1:0]  dc;
  logic [4:0]  digit;
  logic [7:0]  b;
  logic [2:0]  n_res;
  kind_t       r_kind;
  logic [2:0]  r_code;
  logic [7:0]  r_bytes [4];
  logic        enc_en;
  logic [20:0] enc_cp;

  logic grp_done, grp_room, dec_fire;

  // Decode one byte against the current (or restarted) state
  always_comb begin
    b         = inq.in_byte;
    ph        = inq.restart ? PH_TEXT : phase;
    acc       = inq.restart ? 16'd0 : hex_accum;
    hs        = inq.restart ? 16'd0 : high_surrogate;
    dc        = inq.restart ? 2'd0 : digit_count;
    digit     = hex_value(b);
    acc_shift = {acc[11:0], digit[3:0]};

    phase_next          = ph;
    hex_accum_next      = acc;
    high_surrogate_next = hs;
    digit_count_next    = dc;
    n_res               = 3'd0;
    r_kind              = KIND_BYTE;
    r_code              = ERR_QUOTE;
    enc_en              = 1'b0;
    enc_cp              = 21'd0;
    for (int i = 0; i < 4; i++) begin
      r_bytes[i] = 8'd0;
    end

    unique case (ph)
      PH_TEXT: begin
        if (b == CH_QUOTE) begin
          phase_next = PH_ENDED;
          n_res      = 3'd1;
          r_kind     = KIND_END;
        end else if (b == CH_NUL) begin
          phase_next = PH_FAILED;
          n_res      = 3'd1;
          r_kind     = KIND_ERROR;
          r_code     = ERR_QUOTE;
        end else if (b == CH_BSLASH) begin
          phase_next = PH_ESC;
        end else if (b < CH_SPACE) begin
          phase_next = PH_FAILED;
          n_res      = 3'd1;
          r_kind     = KIND_ERROR;
          r_code     = ERR_CONTROL;
        end else begin
          n_res      = 3'd1;
          r_bytes[0] = b;
        end
      end
      PH_ESC: begin
        phase_next = PH_TEXT;
        n_res      = 3'd1;
        case (b)
          CH_QUOTE, CH_BSLASH, CH_SLASH: r_bytes[0] = b;
          CH_B: r_bytes[0] = 8'h08;
          CH_F: r_bytes[0] = 8'h0C;
          CH_N: r_bytes[0] = 8'h0A;
          CH_R: r_bytes[0] = 8'h0D;
          CH_T: r_bytes[0] = 8'h09;
          CH_U: begin
            phase_next       = PH_HEX_A;
            hex_accum_next   = 16'd0;
            digit_count_next = 2'd0;
            n_res            = 3'd0;
          end
          default: begin
            phase_next = PH_FAILED;
            r_kind     = KIND_ERROR;
            r_code     = ERR_ESCAPE;
          end
        endcase
      end
      PH_HEX_A, PH_HEX_B: begin
        if (!digit[4]) begin
          phase_next = PH_FAILED;
          n_res      = 3'd1;
          r_kind     = KIND_ERROR;
          r_code     = ERR_HEX;
        end else if (dc != 2'd3) begin
          hex_accum_next   = acc_shift;
          digit_count_next = 2'(dc + 2'd1);
        end else begin
          hex_accum_next   = acc_shift;
          digit_count_next = 2'd0;
          if (ph == PH_HEX_A) begin
            if (acc_shift >= 16'hD800 && acc_shift <= 16'hDBFF) begin
              high_surrogate_next = acc_shift;
              phase_next          = PH_WANT_BS;
            end else begin
              phase_next = PH_TEXT;
              enc_en     = 1'b1;
              enc_cp     = {5'd0, acc_shift};
            end
          end else if (acc_shift < 16'hDC00 || acc_shift > 16'hDFFF) begin
            phase_next = PH_FAILED;
            n_res      = 3'd1;
            r_kind     = KIND_ERROR;
            r_code     = ERR_SURROGATE;
          end else begin
            phase_next = PH_TEXT;
            enc_en     = 1'b1;
            enc_cp     = {1'b0, hs[9:0], acc_shift[9:0]} + 21'h10000;
          end
        end
      end
      PH_WANT_BS: begin
        if (b != CH_BSLASH) begin
          phase_next = PH_FAILED;
          n_res      = 3'd1;
          r_kind     = KIND_ERROR;
          r_code     = ERR_SURROGATE;
        end else begin
          phase_next = PH_WANT_U;
        end
      end
      PH_WANT_U: begin
        if (b != CH_U) begin
          phase_next = PH_FAILED;
          n_res      = 3'd1;
          r_kind     = KIND_ERROR;
          r_code     = ERR_SURROGATE;
        end else begin
          phase_next       = PH_HEX_B;
          hex_accum_next   = 16'd0;
          digit_count_next = 2'd0;
        end
      end
      default: begin
        // ended or failed: drop bytes until restart
      end
    endcase

    // Encode a code point as UTF-8
    if (enc_en) begin
      if (enc_cp <= 21'h7F) begin
        n_res      = 3'd1;
        r_bytes[0] = enc_cp[7:0];
      end else if (enc_cp <= 21'h7FF) begin
        n_res      = 3'd2;
        r_bytes[0] = {3'b110, enc_cp[10:6]};
        r_bytes[1] = {2'b10, enc_cp[5:0]};
      end else if (enc_cp <= 21'hFFFF) begin
        n_res      = 3'd3;
        r_bytes[0] = {4'b1110, enc_cp[15:12]};
        r_bytes[1] = {2'b10, enc_cp[11:6]};
        r_bytes[2] = {2'b10, enc_cp[5:0]};
      end else begin
        n_res      = 3'd4;
        r_bytes[0] = {5'b11110, enc_cp[20:18]};
        r_bytes[1] = {2'b10, enc_cp[17:12]};
        r_bytes[2] = {2'b10, enc_cp[11:6]};
        r_bytes[3] = {2'b10, enc_cp[5:0]};
      end
    end
  end

  // Handshake control
  assign grp_done   = grp_valid && !res_stall && (grp_idx == grp_cnt);
  assign grp_room   = !grp_valid || grp_done;
  assign dec_fire   = inq_valid && (grp_room || (n_res == 3'd0));
  assign byte_stall = inq_valid && !dec_fire;

  // Hold the input request
  always_ff @(posedge clk) begin
    if (rst) begin
      inq_valid <= 1'b0;
    end else if (byte_valid && !byte_stall) begin
      inq_valid <= 1'b1;
    end else if (dec_fire) begin
      inq_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (byte_valid && !byte_stall) begin
      inq <= byte_data;
    end
  end

  // Advance decoder state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_TEXT;
      hex_accum      <= 16'd0;
      high_surrogate <= 16'd0;
      digit_count    <= 2'd0;
    end else if (dec_fire) begin
      phase          <= phase_next;
      hex_accum      <= hex_accum_next;
      high_surrogate <= high_surrogate_next;
      digit_count    <= digit_count_next;
    end
  end

  // Load and drain the result group
  always_ff @(posedge clk) begin
    if (rst) begin
      grp_valid <= 1'b0;
      grp_idx   <= 2'd0;
    end else if (dec_fire && (n_res != 3'd0)) begin
      grp_valid <= 1'b1;
      grp_idx   <= 2'd0;
    end else if (grp_done) begin
      grp_valid <= 1'b0;
    end else if (grp_valid && !res_stall) begin
      grp_idx <= 2'(grp_idx + 2'd1);
    end
  end

  always_ff @(posedge clk) begin
    if (dec_fire && (n_res != 3'd0)) begin
      grp_kind <= r_kind;
      grp_code <= r_code;
      grp_cnt  <= 2'(n_res - 3'd1);
      for (int i = 0; i < 4; i++) begin
        grp_bytes[i] <= r_bytes[i];
      end
    end
  end

  // Drive the result channel
  assign res_valid           = grp_valid;
  assign res_data.kind       = grp_kind;
  assign res_data.out_byte   = grp_bytes[grp_idx];
  assign res_data.error_code = grp_code;
  assign res_data.last       = (grp_idx == grp_cnt);

endmodule

// File: hw/rtl/jsu_checker.sv
// ----------------------------------------------------------------------------
// jsu_checker
// Port-level checks on the string unescape block, bound to the top level.
// ----------------------------------------------------------------------------
`include "json_string_unescape_utf8_top_macros.svh"

module jsu_checker (
  input logic               clk,
  input logic               rst,
  input logic               byte_valid,
  input logic               byte_stall,
  input jsu_pkg::byte_req_t byte_data,
  input logic               res_valid,
  input logic               res_stall,
  input jsu_pkg::result_t   res_data
);
  import jsu_pkg::*;

  logic res_wait, in_wait, res_other, res_plain, kind_known;

  assign res_wait   = res_valid && res_stall;
  assign in_wait    = byte_valid && byte_stall;
  assign res_other  = res_valid && (res_data.kind != KIND_BYTE);
  assign res_plain  = res_valid && (res_data.kind != KIND_ERROR);
  assign kind_known = (res_data.kind == KIND_BYTE) || (res_data.kind == KIND_END) ||
                      (res_data.kind == KIND_ERROR);

  // Hold a stalled result
  `JSU_ASSERT_NEXT(a_res_hold, res_wait, res_valid && $stable(res_data), "result moved in stall")

  // Hold a stalled request
  `JSU_ASSERT_NEXT(a_byte_hold, in_wait, byte_valid && $stable(byte_data), "request moved")

  // End and error results stand alone
  `JSU_ASSERT_NOW(a_single, res_other, res_data.last, "end or error result not marked last")

  // Error code only on error results
  `JSU_ASSERT_NOW(a_code_zero, res_plain, res_data.error_code == ERR_QUOTE, "stray error code")

  // Only defined kinds leave the block
  `JSU_ASSERT_NOW(a_kind_ok, res_valid, kind_known, "undefined result kind")

endmodule

bind json_string_unescape_utf8_top jsu_checker u_jsu_checker (.*);
